FILE: rtl/pswq_pkg.sv
// ----------------------------------------------------------------------------
// pswq_pkg
// Shared types and constants for the parity-split weighted queue server.
// ----------------------------------------------------------------------------
package pswq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = PTR_W + 1;
  localparam int ID_W        = 31;
  localparam int CAP_W       = 7;
  localparam int STATUS_W    = 2;
  localparam int PHASE_W     = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

  // item commands
  localparam logic CMD_ENQ   = 1'b0;
  localparam logic CMD_SERVE = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOTHING = 2'd2;

  // rotation slots: odd, odd, even
  localparam logic [PHASE_W-1:0] PH_ODD_A = 2'd0;
  localparam logic [PHASE_W-1:0] PH_ODD_B = 2'd1;
  localparam logic [PHASE_W-1:0] PH_EVEN  = 2'd2;

  typedef struct packed {
    logic               hit;        // some queue gets served
    logic               from_even;  // served queue is the even one
    logic [PHASE_W-1:0] next_phase;
  } pick_t;

endpackage

FILE: rtl/pswq_pick.sv
// ----------------------------------------------------------------------------
// pswq_pick
// Weighted round-robin slot picker: walks odd, odd, even from the kept phase
// and skips slots whose queue is empty.
// ----------------------------------------------------------------------------
module pswq_pick
  import pswq_pkg::*;
(
  input  logic [PHASE_W-1:0] phase,
  input  logic               odd_avail,
  input  logic               even_avail,
  output pick_t              pick
);

  always_comb begin
    pick.hit        = odd_avail | even_avail;
    pick.from_even  = 1'b0;
    pick.next_phase = phase;
    unique case (phase)
      PH_ODD_B: begin
        if (odd_avail) begin
          pick.next_phase = PH_EVEN;
        end else if (even_avail) begin
          pick.from_even  = 1'b1;
          pick.next_phase = PH_ODD_A;
        end
      end
      PH_EVEN: begin
        if (even_avail) begin
          pick.from_even  = 1'b1;
          pick.next_phase = PH_ODD_A;
        end else if (odd_avail) begin
          pick.next_phase = PH_ODD_B;
        end
      end
      // first odd slot; the unused code behaves the same
      default: begin
        if (odd_avail) begin
          pick.next_phase = PH_ODD_B;
        end else if (even_avail) begin
          pick.from_even  = 1'b1;
          pick.next_phase = PH_ODD_A;
        end
      end
    endcase
  end

endmodule

FILE: rtl/parity_split_weighted_queue_server_core.sv
// ----------------------------------------------------------------------------
// parity_split_weighted_queue_server_core
// Two ring-buffer FIFOs (odd and even customer numbers) in synchronous RAMs,
// served 2:1 odd/even with empty-slot skipping.
// ----------------------------------------------------------------------------
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+--------------------------
//  input   | in_cmd, in_customer_id                  | start & !busy
//  result  | out_served_id, out_from_even_queue,     | out_valid, one cycle,
//          | out_status, out_all_empty               | cannot be held off
//  config  | cfg_wdata                               | cfg_we
//
//  One item per cycle; busy stays low. The result of an item appears in the
//  cycle after its accept, from the registered RAM read of the head entry.
//  Pointers, counts and the phase live in flops; an update made for one item
//  is seen by the read of the next, so back-to-back items need no forwarding.
//  Synchronous active-low reset clears pointers, counts, phase, capacity
//  (to 64) and the strobe; RAM contents are not cleared.
// ----------------------------------------------------------------------------
module parity_split_weighted_queue_server_core
  import pswq_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_cmd,
  input  logic [ID_W-1:0]     in_customer_id,
  output logic                out_valid,
  output logic [ID_W-1:0]     out_served_id,
  output logic                out_from_even_queue,
  output logic [STATUS_W-1:0] out_status,
  output logic                out_all_empty,
  input  logic                cfg_we,
  input  logic [CAP_W-1:0]    cfg_wdata
);

  logic [ID_W-1:0] odd_mem  [QUEUE_DEPTH];
  logic [ID_W-1:0] even_mem [QUEUE_DEPTH];

  logic [PTR_W-1:0]   odd_head_r, odd_head_nxt, odd_tail_r, odd_tail_nxt;
  logic [PTR_W-1:0]   even_head_r, even_head_nxt, even_tail_r, even_tail_nxt;
  logic [CNT_W-1:0]   odd_cnt_r, odd_cnt_nxt, even_cnt_r, even_cnt_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [CAP_W-1:0]   cap_r;
  logic [CNT_W-1:0]   cap_lim;

  logic               accept;
  logic               is_odd;
  logic               odd_wr, even_wr;
  logic               do_serve;
  pick_t              pick;

  logic [ID_W-1:0]     odd_rd_r, even_rd_r;
  logic                out_valid_r, sel_even_r, served_r;
  logic                from_even_r, from_even_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic                all_empty_r;

  assign busy   = 1'b0;
  assign accept = start & ~busy;
  assign is_odd = in_customer_id[0];

  assign cap_lim = (32'(cap_r) > 32'(QUEUE_DEPTH)) ? CNT_W'(QUEUE_DEPTH)
                                                   : CNT_W'(cap_r);

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  pswq_pick u_pick (
    .phase      (phase_r),
    .odd_avail  (odd_cnt_r != '0),
    .even_avail (even_cnt_r != '0),
    .pick       (pick)
  );

  always_comb begin
    odd_head_nxt  = odd_head_r;
    odd_tail_nxt  = odd_tail_r;
    odd_cnt_nxt   = odd_cnt_r;
    even_head_nxt = even_head_r;
    even_tail_nxt = even_tail_r;
    even_cnt_nxt  = even_cnt_r;
    phase_nxt     = phase_r;
    odd_wr        = 1'b0;
    even_wr       = 1'b0;
    do_serve      = 1'b0;
    from_even_nxt = 1'b0;
    status_nxt    = ST_OK;
    if (accept) begin
      if (in_cmd == CMD_ENQ) begin
        from_even_nxt = ~is_odd;
        if (is_odd) begin
          if (odd_cnt_r >= cap_lim) begin
            status_nxt = ST_FULL;
          end else begin
            odd_wr       = 1'b1;
            odd_tail_nxt = wrap_inc(odd_tail_r);
            odd_cnt_nxt  = odd_cnt_r + 1'b1;
          end
        end else begin
          if (even_cnt_r >= cap_lim) begin
            status_nxt = ST_FULL;
          end else begin
            even_wr       = 1'b1;
            even_tail_nxt = wrap_inc(even_tail_r);
            even_cnt_nxt  = even_cnt_r + 1'b1;
          end
        end
      end else if (pick.hit) begin
        do_serve      = 1'b1;
        from_even_nxt = pick.from_even;
        phase_nxt     = pick.next_phase;
        if (pick.from_even) begin
          even_head_nxt = wrap_inc(even_head_r);
          even_cnt_nxt  = even_cnt_r - 1'b1;
        end else begin
          odd_head_nxt = wrap_inc(odd_head_r);
          odd_cnt_nxt  = odd_cnt_r - 1'b1;
        end
      end else begin
        status_nxt = ST_NOTHING;
      end
    end
  end

  // RAMs: write at tail on enqueue, read head every cycle
  always_ff @(posedge clk) begin
    if (odd_wr) begin
      odd_mem[odd_tail_r] <= in_customer_id;
    end
    odd_rd_r <= odd_mem[odd_head_r];
  end

  always_ff @(posedge clk) begin
    if (even_wr) begin
      even_mem[even_tail_r] <= in_customer_id;
    end
    even_rd_r <= even_mem[even_head_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      odd_head_r  <= '0;
      odd_tail_r  <= '0;
      odd_cnt_r   <= '0;
      even_head_r <= '0;
      even_tail_r <= '0;
      even_cnt_r  <= '0;
      phase_r     <= PH_ODD_A;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      odd_head_r  <= odd_head_nxt;
      odd_tail_r  <= odd_tail_nxt;
      odd_cnt_r   <= odd_cnt_nxt;
      even_head_r <= even_head_nxt;
      even_tail_r <= even_tail_nxt;
      even_cnt_r  <= even_cnt_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= accept;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    served_r    <= do_serve;
    sel_even_r  <= pick.from_even;
    from_even_r <= from_even_nxt;
    status_r    <= status_nxt;
    all_empty_r <= (odd_cnt_nxt == '0) && (even_cnt_nxt == '0);
  end

  assign out_valid           = out_valid_r;
  assign out_served_id       = !served_r ? '0 : (sel_even_r ? even_rd_r : odd_rd_r);
  assign out_from_even_queue = from_even_r;
  assign out_status          = status_r;
  assign out_all_empty       = all_empty_r;

  // ------------------------------------------------------------------------
  // assertions
  // ------------------------------------------------------------------------
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted item produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> !out_valid)
    else $error("result without accepted item");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(odd_cnt_r) <= 32'(QUEUE_DEPTH)) && (32'(even_cnt_r) <= 32'(QUEUE_DEPTH)))
    else $error("queue count above depth");

  a_nothing_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_NOTHING)) |-> (out_all_empty && !out_from_even_queue))
    else $error("empty serve while a queue holds items");

  a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_ODD_A) || (phase_r == PH_ODD_B) || (phase_r == PH_EVEN))
    else $error("rotation phase out of range");

endmodule

FILE: tb/tb_parity_split_weighted_queue_server_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_parity_split_weighted_queue_server_core
// Drives enqueue and serve items into the odd/even queue server and checks
// every result strobe against a cycle-free model of the two ring FIFOs, the
// odd-odd-even rotation and capacity, or a typed directed-row result. Starts
// with a directed table, then runs random phases under several capacities.
// ----------------------------------------------------------------------------
module tb_parity_split_weighted_queue_server_core;
  import pswq_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam logic [ID_W-1:0] ID_TOP   = 31'h7FFF_FFFF;
  localparam logic [ID_W-1:0] ID_HIGH  = 31'h7FFF_FFFE;

  typedef struct packed {
    logic [ID_W-1:0]     served_id;
    logic                from_even;
    logic [STATUS_W-1:0] status;
    logic                all_empty;
  } queue_result_t;

  localparam queue_result_t NO_RESULT = '0;

  typedef enum logic {DO_ITEM, DO_CAP} row_op_t;

  typedef struct packed {
    row_op_t         op;
    logic            cmd;
    logic [ID_W-1:0] id;     // capacity value on DO_CAP rows
    logic            typed;
    queue_result_t   res;
  } dir_row_t;

  localparam int DIR_N = 28;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic                in_cmd = 1'b0;
  logic [ID_W-1:0]     in_customer_id = '0;
  logic                out_valid;
  logic [ID_W-1:0]     out_served_id;
  logic                out_from_even_queue;
  logic [STATUS_W-1:0] out_status;
  logic                out_all_empty;
  logic                cfg_we = 1'b0;
  logic [CAP_W-1:0]    cfg_wdata = '0;

  parity_split_weighted_queue_server_core dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_cmd              (in_cmd),
    .in_customer_id      (in_customer_id),
    .out_valid           (out_valid),
    .out_served_id       (out_served_id),
    .out_from_even_queue (out_from_even_queue),
    .out_status          (out_status),
    .out_all_empty       (out_all_empty),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // queue model state
  logic [ID_W-1:0]    odd_ring  [QUEUE_DEPTH];
  logic [ID_W-1:0]    even_ring [QUEUE_DEPTH];
  logic [PTR_W-1:0]   odd_rd, odd_wr, even_rd, even_wr;
  logic [CNT_W-1:0]   odd_fill, even_fill;
  logic [PHASE_W-1:0] slot_phase;
  logic [CAP_W-1:0]   cap_reg;

  queue_result_t expected_results [$];
  int unsigned   err_cnt = 0;
  int unsigned   cycle_cnt = 0;
  bit            idle_en = 1'b1;
  dir_row_t      dir_rows [DIR_N];

  function automatic queue_result_t predict_queue_step(input logic cmd,
                                                       input logic [ID_W-1:0] id);
    queue_result_t      r;
    logic [CNT_W-1:0]   lim;
    logic [PHASE_W-1:0] ph;
    logic [PHASE_W-1:0] slot;
    bit                 done;
    r = NO_RESULT;
    done = 1'b0;
    lim = (cap_reg > QUEUE_DEPTH) ? CNT_W'(QUEUE_DEPTH) : CNT_W'(cap_reg);
    if (cmd == CMD_ENQ) begin
      r.from_even = ~id[0];
      if (id[0]) begin
        if (odd_fill >= lim) begin
          r.status = ST_FULL;
        end else begin
          odd_ring[odd_wr] = id;
          odd_wr = odd_wr + 1'b1;
          odd_fill = odd_fill + 1'b1;
        end
      end else begin
        if (even_fill >= lim) begin
          r.status = ST_FULL;
        end else begin
          even_ring[even_wr] = id;
          even_wr = even_wr + 1'b1;
          even_fill = even_fill + 1'b1;
        end
      end
    end else begin
      ph = (slot_phase > PH_EVEN) ? PH_ODD_A : slot_phase;
      for (int k = 0; k < 3 && !done; k++) begin
        slot = PHASE_W'((int'(ph) + k) % 3);
        if (slot == PH_EVEN) begin
          if (even_fill != 0) begin
            r.served_id = even_ring[even_rd];
            r.from_even = 1'b1;
            even_rd = even_rd + 1'b1;
            even_fill = even_fill - 1'b1;
            slot_phase = PH_ODD_A;
            done = 1'b1;
          end
        end else if (odd_fill != 0) begin
          r.served_id = odd_ring[odd_rd];
          odd_rd = odd_rd + 1'b1;
          odd_fill = odd_fill - 1'b1;
          slot_phase = slot + 1'b1;
          done = 1'b1;
        end
      end
      if (!done) r.status = ST_NOTHING;
    end
    r.all_empty = (odd_fill == 0) && (even_fill == 0);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got 0x%0h, expected 0x%0h at cycle %0d",
             what, got, want, cycle_cnt);
    err_cnt++;
  endtask

  // one item; the accept is decided from busy sampled mid-cycle
  task automatic send_item(input logic cmd, input logic [ID_W-1:0] id,
                           input logic typed, input queue_result_t typed_res);
    queue_result_t r;
    bit            taken;
    taken = 1'b0;
    while (idle_en && $urandom_range(0, 99) < 34) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_cmd <= cmd;
    in_customer_id <= id;
    while (!taken) begin
      @(negedge clk);
      if (!busy) begin
        taken = 1'b1;
        r = predict_queue_step(cmd, id);
        expected_results.push_back(typed ? typed_res : r);
      end
      @(posedge clk);
    end
  endtask

  // capacity changes only with nothing in flight
  task automatic set_capacity(input logic [CAP_W-1:0] value);
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    cap_reg = value;
  endtask

  always @(negedge clk) begin
    queue_result_t want;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing pending", out_served_id, 0);
      end else begin
        want = expected_results.pop_front();
        if (out_served_id !== want.served_id)
          report_mismatch("served_id", out_served_id, want.served_id);
        if (out_from_even_queue !== want.from_even)
          report_mismatch("from_even_queue", out_from_even_queue, want.from_even);
        if (out_status !== want.status)
          report_mismatch("status", out_status, want.status);
        if (out_all_empty !== want.all_empty)
          report_mismatch("all_empty", out_all_empty, want.all_empty);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("parity_split_weighted_queue_server_core test failed");
      $finish;
    end
  end

  initial begin
    logic [CAP_W-1:0] cap;
    int               n_items;
    int               enq_pct;
    logic             cmd;
    logic [ID_W-1:0]  id;

    odd_rd = '0; odd_wr = '0; odd_fill = '0;
    even_rd = '0; even_wr = '0; even_fill = '0;
    slot_phase = PH_ODD_A;
    cap_reg = CAP_RESET;

    dir_rows[0]  = '{DO_ITEM, CMD_SERVE, 31'd0, 1'b1, '{31'd0, 1'b0, ST_NOTHING, 1'b1}};
    dir_rows[1]  = '{DO_ITEM, CMD_ENQ, 31'd0, 1'b1, '{31'd0, 1'b1, ST_OK, 1'b0}};
    dir_rows[2]  = '{DO_ITEM, CMD_ENQ, ID_TOP, 1'b1, '{31'd0, 1'b0, ST_OK, 1'b0}};
    dir_rows[3]  = '{DO_ITEM, CMD_ENQ, ID_HIGH, 1'b0, NO_RESULT};
    dir_rows[4]  = '{DO_ITEM, CMD_ENQ, 31'd1, 1'b0, NO_RESULT};
    dir_rows[5]  = '{DO_ITEM, CMD_ENQ, 31'h5555_5555, 1'b0, NO_RESULT};
    dir_rows[6]  = '{DO_ITEM, CMD_ENQ, 31'h2AAA_AAAA, 1'b0, NO_RESULT};
    dir_rows[7]  = '{DO_ITEM, CMD_SERVE, ID_TOP, 1'b0, NO_RESULT};
    dir_rows[8]  = '{DO_ITEM, CMD_SERVE, 31'd0, 1'b0, NO_RESULT};
    dir_rows[9]  = '{DO_ITEM, CMD_SERVE, 31'd2, 1'b0, NO_RESULT};
    dir_rows[10] = '{DO_ITEM, CMD_SERVE, 31'd3, 1'b0, NO_RESULT};
    dir_rows[11] = '{DO_ITEM, CMD_SERVE, 31'd0, 1'b0, NO_RESULT};
    dir_rows[12] = '{DO_ITEM, CMD_SERVE, 31'd0, 1'b0, NO_RESULT};
    dir_rows[13] = '{DO_ITEM, CMD_SERVE, 31'd0, 1'b1, '{31'd0, 1'b0, ST_NOTHING, 1'b1}};
    dir_rows[14] = '{DO_CAP, CMD_ENQ, 31'd1, 1'b0, NO_RESULT};
    dir_rows[15] = '{DO_ITEM, CMD_ENQ, 31'd3, 1'b0, NO_RESULT};
    dir_rows[16] = '{DO_ITEM, CMD_ENQ, 31'd5, 1'b1, '{31'd0, 1'b0, ST_FULL, 1'b0}};
    dir_rows[17] = '{DO_ITEM, CMD_ENQ, 31'd4, 1'b0, NO_RESULT};
    dir_rows[18] = '{DO_ITEM, CMD_ENQ, 31'd6, 1'b1, '{31'd0, 1'b1, ST_FULL, 1'b0}};
    // zero capacity: everything refused, held entries still drain
    dir_rows[19] = '{DO_CAP, CMD_ENQ, 31'd0, 1'b0, NO_RESULT};
    dir_rows[20] = '{DO_ITEM, CMD_ENQ, 31'd8, 1'b1, '{31'd0, 1'b1, ST_FULL, 1'b0}};
    dir_rows[21] = '{DO_ITEM, CMD_ENQ, 31'd9, 1'b1, '{31'd0, 1'b0, ST_FULL, 1'b0}};
    dir_rows[22] = '{DO_ITEM, CMD_SERVE, 31'd0, 1'b0, NO_RESULT};
    dir_rows[23] = '{DO_ITEM, CMD_SERVE, 31'd0, 1'b0, NO_RESULT};
    dir_rows[24] = '{DO_CAP, CMD_ENQ, 31'd127, 1'b0, NO_RESULT};
    dir_rows[25] = '{DO_ITEM, CMD_ENQ, 31'd11, 1'b0, NO_RESULT};
    dir_rows[26] = '{DO_ITEM, CMD_SERVE, 31'd0, 1'b0, NO_RESULT};
    dir_rows[27] = '{DO_ITEM, CMD_SERVE, 31'd0, 1'b1, '{31'd0, 1'b0, ST_NOTHING, 1'b1}};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < DIR_N; r++) begin
      if (dir_rows[r].op == DO_CAP)
        set_capacity(CAP_W'(dir_rows[r].id));
      else
        send_item(dir_rows[r].cmd, dir_rows[r].id, dir_rows[r].typed, dir_rows[r].res);
    end

    for (int p = 0; p < 10; p++) begin
      case (p)
        0: cap = 7'd64;
        1: cap = 7'd127;
        2: cap = 7'd1;
        3: cap = 7'd0;
        4: cap = 7'd2;
        5: cap = CAP_W'($urandom_range(3, 63));
        6: cap = CAP_W'($urandom_range(65, 126));
        8: cap = CAP_W'($urandom_range(1, 16));
        default: cap = 7'd64;
      endcase
      set_capacity(cap);
      idle_en = (p != 7);   // one long back-to-back stretch
      n_items = (cap == 0) ? 40 : 190;
      enq_pct = 50;
      for (int i = 0; i < n_items; i++) begin
        // fill / drain waves so both full and empty are reached
        if (i % 48 == 0) begin
          case ($urandom_range(0, 2))
            0: enq_pct = 85;
            1: enq_pct = 50;
            default: enq_pct = 20;
          endcase
        end
        cmd = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQ : CMD_SERVE;
        case ($urandom_range(0, 15))
          0: id = 31'd0;
          1: id = 31'd1;
          2: id = ID_HIGH;
          3: id = ID_TOP;
          default: id = ID_W'($urandom);
        endcase
        send_item(cmd, id, 1'b0, NO_RESULT);
      end
    end

    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (err_cnt == 0)
      $display("parity_split_weighted_queue_server_core test passed");
    else
      $display("parity_split_weighted_queue_server_core test failed");
    $finish;
  end

endmodule
